// ===== rtl/core/priority_voice_allocator_assert.svh =====
// Assertion macros for the voice allocator.
// Each macro expects clk and arst_n in the enclosing module.
`ifndef PRIORITY_VOICE_ALLOCATOR_ASSERT_SVH
`define PRIORITY_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define PVA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("voice allocator: same-cycle check failed");

// Next-cycle implication.
`define PVA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("voice allocator: next-cycle check failed");

`endif

// ===== rtl/core/pva_pkg.sv =====
`default_nettype none
package pva_pkg;

	localparam int NUM_VOICES_DEF      = 48;
	localparam int VOICES_PER_CORE_DEF = 24;
	localparam int NUM_GROUPS_DEF      = 16;

	localparam int VOICE_W = 6;
	localparam int PRIO_W  = 7;
	localparam int TICK_W  = 32;
	localparam int GROUP_W = 4;
	localparam int FUNC_W  = 3;
	localparam int RANGE_W = 48;
	localparam int NUM_RANGE_WORDS = 4;
	localparam int RIDX_W  = 2;

	localparam logic [FUNC_W-1:0] FN_ALLOC       = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ALLOC_EXT   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_ALLOC_NOISE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DONE        = 3'd3;
	localparam logic [FUNC_W-1:0] FN_HARD_FREE   = 3'd4;

	localparam logic [PRIO_W-1:0]  PRIO_NOSTEAL   = 7'h7E;
	localparam logic [PRIO_W-1:0]  PRIO_PERMANENT = 7'h7F;
	localparam logic [RANGE_W-1:0] RANGE_RESET    = 48'hBC0BC0BC0BC0;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [GROUP_W-1:0] group_id;
		logic [PRIO_W-1:0]  req_priority;
		logic [VOICE_W-1:0] voice_index;
		logic [TICK_W-1:0]  now_tick;
	} pva_req_t;

	typedef struct packed {
		logic               granted;
		logic [VOICE_W-1:0] voice_out;
		logic               evicted;
		logic               noise_core;
	} pva_rsp_t;

	// One voice record; the valid bits are kept apart from it, and a voice whose valid bit is clear is free.
	typedef struct packed {
		logic               ext;
		logic [PRIO_W-1:0]  prio;
		logic [TICK_W-1:0]  tick;
	} pva_entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/priority_voice_allocator.sv =====
// Sequence: an allocate runs START, then SCAN to the first free voice or the window end;
//   stealing adds DRAIN and DECIDE, a grant CLAIM, and all end in FINISH. Noise tries core 0
//   (NOISE0), then core 1 (NOISE1). Done: DONE_RD, DONE_CHK; others go straight to FINISH.
// Throughput: one transaction at a time; the scan reads one voice record per cycle
//   through the read port of the voice memory.
// Reset: async active-low; all voices free, range words 0xBC0BC0BC0BC0, noise owners -1.
`default_nettype none
`include "priority_voice_allocator_assert.svh"
module priority_voice_allocator #(
	parameter int NUM_VOICES      = pva_pkg::NUM_VOICES_DEF,
	parameter int VOICES_PER_CORE = pva_pkg::VOICES_PER_CORE_DEF,
	parameter int NUM_GROUPS      = pva_pkg::NUM_GROUPS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output      logic                            req_ready,
	input  wire pva_pkg::pva_req_t               req,
	output      logic                            rsp_valid,
	input  wire logic                            rsp_ready,
	output      pva_pkg::pva_rsp_t               rsp,
	input  wire logic                            cfg_we,
	input  wire logic [pva_pkg::RIDX_W-1:0]      cfg_index,
	input  wire logic [pva_pkg::RANGE_W-1:0]     cfg_data
);
	import pva_pkg::*;

	// Memory address width follows the voice count.
	localparam int AW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(NUM_VOICES - 1);
	localparam logic [VOICE_W:0]   NV_C       = (VOICE_W + 1)'(NUM_VOICES);
	localparam logic [VOICE_W-1:0] VPC_C      = VOICE_W'(VOICES_PER_CORE);
	localparam logic [VOICE_W-1:0] VPC_LAST   = VOICE_W'(VOICES_PER_CORE - 1);
	localparam logic [GROUP_W-1:0] LAST_GROUP = GROUP_W'(NUM_GROUPS - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_NOISE0,
		S_NOISE1,
		S_START,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_CLAIM,
		S_DONE_RD,
		S_DONE_CHK,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic [RANGE_W-1:0]        range_q [NUM_RANGE_WORDS];
	logic [NUM_VOICES-1:0]     vvalid_q;
	logic signed [7:0]         owner0_q;
	logic signed [7:0]         owner1_q;

	// Latched transaction
	logic [FUNC_W-1:0]         func_q;
	logic [PRIO_W-1:0]         prio_q;
	logic [TICK_W-1:0]         tick_q;
	logic [VOICE_W-1:0]        lo_q;
	logic [VOICE_W-1:0]        hi_q;
	logic                      core_q;

	// Scan window and cursor
	logic [VOICE_W-1:0]        win_lo_q;
	logic [VOICE_W-1:0]        win_hi_q;
	logic [VOICE_W-1:0]        addr_q;

	// Read stage of the scan
	logic                      rd_vld_s1;
	logic [VOICE_W-1:0]        rd_idx_s1;
	pva_entry_t                rd_data_s1;

	// Running victim
	logic [VOICE_W-1:0]        vic_idx_q;
	pva_entry_t                vic_q;

	logic [VOICE_W-1:0]        claim_idx_q;
	logic                      ev_q;
	pva_rsp_t                  res_q;
	pva_rsp_t                  out_q;
	logic                      out_valid_q;

	pva_entry_t                mem [NUM_VOICES];

	// Range decode of the incoming group
	logic [GROUP_W-1:0]        grp_c;
	logic [RANGE_W-1:0]        word_c;
	logic [11:0]               fld_c;
	logic [VOICE_W-1:0]        mn_c;
	logic [VOICE_W-1:0]        mx_c;

	logic                      better_c;
	logic                      prio_gt0_c;
	logic                      prio_gt1_c;
	logic                      is_noise_c;
	state_t                    fail_state_c;

	assign grp_c  = (req.group_id > LAST_GROUP) ? LAST_GROUP : req.group_id;
	assign word_c = range_q[grp_c[3:2]];
	assign fld_c  = word_c[12 * grp_c[1:0] +: 12];
	assign mn_c   = fld_c[5:0];
	assign mx_c   = (fld_c[11:6] > LAST_VOICE) ? LAST_VOICE : fld_c[11:6];

	// Victim compare: non-external candidate with lower priority, or equal and older.
	assign better_c = !rd_data_s1.ext &&
		((rd_data_s1.prio < vic_q.prio) ||
		 ((rd_data_s1.prio == vic_q.prio) && (rd_data_s1.tick < vic_q.tick)));

	assign prio_gt0_c = $signed({1'b0, prio_q}) > owner0_q;
	assign prio_gt1_c = $signed({1'b0, prio_q}) > owner1_q;
	assign is_noise_c = (func_q == FN_ALLOC_NOISE);

	// A refused noise request on core 0 falls through to core 1.
	assign fail_state_c = (is_noise_c && !core_q) ? S_NOISE1 : S_FINISH;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Voice record memory: one write (claim), one registered read per cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_CLAIM) begin
			mem[claim_idx_q[AW-1:0]] <= '{ext: (func_q == FN_ALLOC_EXT), prio: prio_q,
				tick: tick_q};
		end
		rd_data_s1 <= mem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < NUM_RANGE_WORDS; i++) begin
				range_q[i] <= RANGE_RESET;
			end
			vvalid_q    <= '0;
			owner0_q    <= '1;
			owner1_q    <= '1;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				range_q[cfg_index] <= cfg_data;
			end
			// the finish state refills the slot itself
			if (out_valid_q && rsp_ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			// A busy voice under the cursor is read for the victim compare.
			rd_vld_s1 <= (state_q == S_SCAN) && vvalid_q[addr_q[AW-1:0]];

			// Victim tracking; the first voice of the window always seeds it.
			if (rd_vld_s1 && ((rd_idx_s1 == win_lo_q) || better_c)) begin
				vic_idx_q <= rd_idx_s1;
				vic_q     <= rd_data_s1;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						func_q   <= req.func;
						prio_q   <= req.req_priority;
						tick_q   <= req.now_tick;
						lo_q     <= mn_c;
						hi_q     <= mx_c;
						win_lo_q <= mn_c;
						win_hi_q <= mx_c;
						addr_q   <= req.voice_index;
						core_q   <= 1'b0;
						res_q    <= '0;
						case (req.func)
							FN_ALLOC, FN_ALLOC_EXT: state_q <= S_START;
							FN_ALLOC_NOISE:         state_q <= S_NOISE0;
							FN_DONE:                state_q <= S_DONE_RD;
							FN_HARD_FREE: begin
								if ({1'b0, req.voice_index} < NV_C) begin
									vvalid_q[req.voice_index[AW-1:0]] <= 1'b0;
								end
								state_q <= S_FINISH;
							end
							default:                state_q <= S_FINISH;
						endcase
					end
				end
				S_NOISE0: begin
					if (prio_gt0_c && (lo_q < VPC_C)) begin
						win_lo_q <= lo_q;
						win_hi_q <= (hi_q >= VPC_C) ? VPC_LAST : hi_q;
						state_q  <= S_START;
					end else begin
						state_q  <= S_NOISE1;
					end
				end
				S_NOISE1: begin
					core_q <= 1'b1;
					if (prio_gt1_c && (hi_q >= VPC_C)) begin
						win_lo_q <= (lo_q < VPC_C) ? VPC_C : lo_q;
						win_hi_q <= hi_q;
						state_q  <= S_START;
					end else begin
						state_q  <= S_FINISH;
					end
				end
				S_START: begin
					addr_q <= win_lo_q;
					if (win_lo_q > win_hi_q) begin
						state_q <= fail_state_c;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!vvalid_q[addr_q[AW-1:0]]) begin
						// lowest free voice wins outright
						claim_idx_q <= addr_q;
						ev_q        <= 1'b0;
						state_q     <= S_CLAIM;
					end else begin
						rd_idx_s1 <= addr_q;
						if (addr_q == win_hi_q) begin
							state_q <= S_DRAIN;
						end else begin
							addr_q <= addr_q + VOICE_W'(1);
						end
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if ((prio_q < vic_q.prio) || (vic_q.prio >= PRIO_NOSTEAL) || vic_q.ext)
					begin
						state_q <= fail_state_c;
					end else begin
						claim_idx_q <= vic_idx_q;
						ev_q        <= 1'b1;
						state_q     <= S_CLAIM;
					end
				end
				S_CLAIM: begin
					vvalid_q[claim_idx_q[AW-1:0]] <= 1'b1;
					res_q <= '{granted: 1'b1, voice_out: claim_idx_q, evicted: ev_q,
						noise_core: core_q};
					if (is_noise_c) begin
						if (core_q) begin
							owner1_q <= $signed({1'b0, prio_q});
						end else begin
							owner0_q <= $signed({1'b0, prio_q});
						end
					end
					state_q <= S_FINISH;
				end
				S_DONE_RD: begin
					state_q <= S_DONE_CHK;
				end
				S_DONE_CHK: begin
					// permanent voices survive a done; a free voice stays free
					if (({1'b0, addr_q} < NV_C) && (rd_data_s1.prio != PRIO_PERMANENT)) begin
						vvalid_q[addr_q[AW-1:0]] <= 1'b0;
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || rsp_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PVA_ASSERT_IMPL(a_nogrant_zero, rsp_valid && !rsp.granted,
		(rsp.voice_out == '0) && !rsp.evicted && !rsp.noise_core)
	`PVA_ASSERT_IMPL(a_grant_range, rsp_valid && rsp.granted, ({1'b0, rsp.voice_out} < NV_C))
	`PVA_ASSERT_NEXT(a_claim_marks, state_q == S_CLAIM, vvalid_q[$past(claim_idx_q[AW-1:0])])
	`PVA_ASSERT_IMPL(a_idle_no_read, req_ready, !rd_vld_s1)

endmodule
`default_nettype wire

// ===== test/voice_alloc_checker.sv =====
`timescale 1ns / 100ps
module voice_alloc_checker
	import pva_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	input  wire logic                  req_ready,
	input  wire pva_req_t              req,
	input  wire logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	input  wire pva_rsp_t              rsp,
	input  wire logic                  cfg_we,
	input  wire logic [RIDX_W-1:0]     cfg_index,
	input  wire logic [RANGE_W-1:0]    cfg_data,
	output int                         mismatches,
	output int                         pending,
	output logic [NUM_VOICES_DEF-1:0]  claimed
);

	localparam int NV  = NUM_VOICES_DEF;
	localparam int VPC = VOICES_PER_CORE_DEF;

	typedef enum logic [1:0] {
		VS_FREE = 2'd0,
		VS_BUSY = 2'd2,
		VS_EXT  = 2'd3
	} vstate_t;

	logic [RANGE_W-1:0] range_q [NUM_RANGE_WORDS];
	vstate_t            vstate [NV];
	logic [PRIO_W-1:0]  vprio [NV];
	logic [TICK_W-1:0]  vtick [NV];
	logic signed [7:0]  noise_owner [2];
	pva_rsp_t           grant_q [$];
	pva_rsp_t           want;

	function automatic void take_voice(int v, logic [PRIO_W-1:0] p, logic [TICK_W-1:0] t);
		vstate[v] = VS_BUSY;
		vprio[v] = p;
		vtick[v] = t;
		claimed[v] = 1'b1;
	endfunction

	// Lowest free voice in [mn, mx], else steal the lowest priority / oldest voice.
	function automatic int alloc_span(logic [PRIO_W-1:0] p, int mn, int mx,
			logic [TICK_W-1:0] t, output bit stole);
		int i;
		int vic;
		stole = 1'b0;
		if (mn > mx)
			return -1;
		for (i = mn; i <= mx; i++) begin
			if (vstate[i] == VS_FREE) begin
				take_voice(i, p, t);
				return i;
			end
		end
		vic = mn;
		for (i = mn + 1; i <= mx; i++) begin
			if (vstate[i] != VS_EXT && (vprio[i] < vprio[vic] ||
					(vprio[i] == vprio[vic] && vtick[i] < vtick[vic])))
				vic = i;
		end
		if (p < vprio[vic] || vprio[vic] >= PRIO_NOSTEAL || vstate[vic] == VS_EXT)
			return -1;
		stole = 1'b1;
		take_voice(vic, p, t);
		return vic;
	endfunction

	function automatic pva_rsp_t predict_grant(pva_req_t r);
		logic [11:0]       span;
		int                mn;
		int                mx;
		int                v;
		bit                stole;
		logic              core;
		logic signed [7:0] rank;
		pva_rsp_t          o;
		span = range_q[r.group_id[3:2]][r.group_id[1:0] * 12 +: 12];
		mn = int'(span[5:0]);
		mx = int'(span[11:6]);
		if (mx > NV - 1)
			mx = NV - 1;
		rank = $signed({1'b0, r.req_priority});
		v = -1;
		stole = 1'b0;
		core = 1'b0;
		case (r.func)
			FN_ALLOC, FN_ALLOC_EXT: begin
				v = alloc_span(r.req_priority, mn, mx, r.now_tick, stole);
				if (v >= 0 && r.func == FN_ALLOC_EXT)
					vstate[v] = VS_EXT;
			end
			FN_ALLOC_NOISE: begin
				if (noise_owner[0] < rank && mn < VPC) begin
					v = alloc_span(r.req_priority, mn, (mx >= VPC) ? VPC - 1 : mx,
						r.now_tick, stole);
					if (v >= 0)
						noise_owner[0] = rank;
				end
				if (v < 0 && noise_owner[1] < rank && mx >= VPC) begin
					v = alloc_span(r.req_priority, (mn < VPC) ? VPC : mn, mx,
						r.now_tick, stole);
					if (v >= 0) begin
						noise_owner[1] = rank;
						core = 1'b1;
					end
				end
			end
			FN_DONE: begin
				if (r.voice_index < NV && vprio[r.voice_index] != PRIO_PERMANENT)
					vstate[r.voice_index] = VS_FREE;
			end
			FN_HARD_FREE: begin
				if (r.voice_index < NV)
					vstate[r.voice_index] = VS_FREE;
			end
			default: ;
		endcase
		o.granted = (v >= 0);
		o.voice_out = (v >= 0) ? v[VOICE_W-1:0] : '0;
		o.evicted = (v >= 0) && stole;
		o.noise_core = (v >= 0) ? core : 1'b0;
		return o;
	endfunction

	task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (vstate[i]) begin
				vstate[i] = VS_FREE;
				vprio[i] = '0;
				vtick[i] = '0;
			end
			foreach (range_q[i])
				range_q[i] = RANGE_RESET;
			foreach (noise_owner[i])
				noise_owner[i] = -8'sd1;
			claimed = '0;
			grant_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				range_q[cfg_index] = cfg_data;
			// Check before predicting: a result leaving now belongs to an older request.
			if (rsp_valid && rsp_ready) begin
				if (grant_q.size() == 0) begin
					$display("%0t: unexpected transaction %p", $time, rsp);
					mismatches++;
				end else begin
					want = grant_q.pop_front();
					check_field("granted", 32'(want.granted), 32'(rsp.granted));
					check_field("voice_out", 32'(want.voice_out), 32'(rsp.voice_out));
					check_field("evicted", 32'(want.evicted), 32'(rsp.evicted));
					check_field("noise_core", 32'(want.noise_core), 32'(rsp.noise_core));
				end
			end
			if (req_valid && req_ready)
				grant_q.push_back(predict_grant(req));
			pending = grant_q.size();
		end
	end

endmodule

// ===== test/priority_voice_allocator_tb.sv =====
`timescale 1ns / 100ps
// Voice allocator bench: the top only makes stimulus and judges; all prediction and
// comparison lives in the checker instance, which watches both channels and the
// register write port.
module priority_voice_allocator_tb;
	import pva_pkg::*;

	localparam int NV  = NUM_VOICES_DEF;
	localparam int VPC = VOICES_PER_CORE_DEF;
	// Longest transaction: a noise request that scans its core 0 part, then its core 1 part.
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT   = 1_500_000;
	// Undefined function codes, expected to change nothing.
	localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;
	// Long receiver hold-off: fires after this many results, then again every CHOKE_EVERY.
	localparam int CHOKE_FIRST = 300;
	localparam int CHOKE_EVERY = 500;
	localparam int CHOKE_LEN   = 700;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	pva_req_t             req;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	pva_rsp_t             rsp;
	logic                 cfg_we;
	logic [RIDX_W-1:0]    cfg_index;
	logic [RANGE_W-1:0]   cfg_data;

	int                   errors;
	int                   pending;
	logic [NV-1:0]        claimed;
	logic [RANGE_W-1:0]   range_words [NUM_RANGE_WORDS];
	int                   cycles = 0;
	int                   noise_seen = 0;
	int                   stall_left = 0;
	int                   rsp_taken = 0;
	int                   choke_at = CHOKE_FIRST;
	int                   rcv_cyc = 0;

	always #6 clk = ~clk;

	priority_voice_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	voice_alloc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (errors),
		.pending    (pending),
		.claimed    (claimed)
	);

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// One group's 12-bit range field: max voice in the upper six bits.
	function automatic logic [11:0] span(logic [5:0] mn, logic [5:0] mx);
		return {mx, mn};
	endfunction

	function automatic pva_req_t mk_item(logic [FUNC_W-1:0] f, int g, logic [PRIO_W-1:0] p,
			int vi, logic [TICK_W-1:0] t);
		pva_req_t r;
		r.func = f;
		r.group_id = g[GROUP_W-1:0];
		r.req_priority = p;
		r.voice_index = vi[VOICE_W-1:0];
		r.now_tick = t;
		return r;
	endfunction

	// Mostly short ranges so that voices run out and stealing kicks in; some
	// straddle the core boundary, some are empty, some are raw bit patterns.
	function automatic logic [RANGE_W-1:0] rand_range_word();
		logic [RANGE_W-1:0] w;
		int                 k;
		int                 mn;
		int                 mx;
		for (k = 0; k < 4; k++) begin
			case ($urandom_range(0, 9))
				0: begin
					mn = $urandom_range(0, 63);
					mx = $urandom_range(0, 63);
				end
				1: begin
					mn = $urandom_range(1, NV - 1);
					mx = $urandom_range(0, mn - 1);
				end
				2: begin
					mn = $urandom_range(VPC - 4, VPC - 1);
					mx = $urandom_range(VPC, VPC + 4);
				end
				default: begin
					mn = $urandom_range(0, NV - 1);
					mx = mn + $urandom_range(0, 5);
				end
			endcase
			w[k * 12 +: 12] = span(mn[5:0], mx[5:0]);
		end
		return w;
	endfunction

	// Random request. A done only names a voice that has been granted at least once
	// (its priority was never written otherwise), or an index past the last voice.
	function automatic pva_req_t rand_item();
		pva_req_t r;
		int       sel;
		int       tries;
		int       np;
		r.group_id = GROUP_W'($urandom_range(0, 15));
		r.voice_index = VOICE_W'($urandom_range(0, (1 << VOICE_W) - 1));
		r.now_tick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: r.req_priority = PRIO_W'($urandom_range(40, 47));
			4, 5, 6:    r.req_priority = PRIO_W'($urandom_range(0, PRIO_PERMANENT));
			7:          r.req_priority = PRIO_NOSTEAL;
			8:          r.req_priority = ($urandom_range(0, 2) == 0) ? PRIO_PERMANENT
			                                               : PRIO_NOSTEAL - PRIO_W'(1);
			default:    r.req_priority = PRIO_W'($urandom_range(0, 3));
		endcase
		sel = $urandom_range(0, 99);
		if (sel < 48) begin
			r.func = FN_ALLOC;
		end else if (sel < 56) begin
			r.func = FN_ALLOC_EXT;
		end else if (sel < 70) begin
			// Noise owners only ever rise, so ramp the priority slowly over the run
			// to keep noise grants happening on both cores until late.
			r.func = FN_ALLOC_NOISE;
			np = noise_seen * 2 / 3 + $urandom_range(0, 3);
			r.req_priority = (np > PRIO_PERMANENT) ? PRIO_PERMANENT : np[PRIO_W-1:0];
			noise_seen++;
		end else if (sel < 85) begin
			r.func = FN_DONE;
			for (tries = 0; tries < 16; tries++) begin
				r.voice_index = VOICE_W'($urandom_range(0, NV - 1));
				if (claimed[r.voice_index])
					break;
			end
			if (!claimed[r.voice_index] || $urandom_range(0, 9) == 0)
				r.voice_index = VOICE_W'($urandom_range(NV, (1 << VOICE_W) - 1));
		end else if (sel < 97) begin
			r.func = FN_HARD_FREE;
			if ($urandom_range(0, 9) != 0)
				r.voice_index = VOICE_W'($urandom_range(0, NV - 1));
		end else begin
			r.func = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
		end
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance, so a
	// back-to-back transaction keeps valid high with a single assignment per step.
	task automatic push_req(pva_req_t r, int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drain all outstanding results, then give the block time to go fully idle.
	task automatic settle();
		req_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes every range word, one per cycle, only while the block is idle.
	task automatic load_ranges();
		int w;
		for (w = 0; w < NUM_RANGE_WORDS; w++) begin
			cfg_we <= 1'b1;
			cfg_index <= w[RIDX_W-1:0];
			cfg_data <= range_words[w];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int n;
		int ph;
		int n_items;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset ranges (every group spans all voices).
		// Noise: core 0 while its owner is below, then core 1 once core 0 is held.
		push_req(mk_item(FN_ALLOC_NOISE, 0, 0, 0, 0), pick_gap());
		push_req(mk_item(FN_ALLOC_NOISE, 0, 0, 0, 1), pick_gap());
		push_req(mk_item(FN_ALLOC_NOISE, 15, 1, 0, 2), pick_gap());
		// External voice at top priority and latest tick, then a permanent voice.
		push_req(mk_item(FN_ALLOC_EXT, 15, PRIO_PERMANENT, 0, '1), pick_gap());
		push_req(mk_item(FN_ALLOC, 7, PRIO_PERMANENT, 0, 3), pick_gap());
		// Done leaves the permanent voice allocated; hard free clears it.
		push_req(mk_item(FN_DONE, 0, 0, 3, 0), pick_gap());
		push_req(mk_item(FN_HARD_FREE, 0, 0, 3, 0), pick_gap());
		// Voice index past the end does nothing.
		push_req(mk_item(FN_DONE, 0, 0, (1 << VOICE_W) - 1, 0), pick_gap());
		push_req(mk_item(FN_HARD_FREE, 0, 0, NV, 0), pick_gap());
		// Undefined function codes with every other field at its maximum.
		push_req(mk_item(FN_UNUSED_LO, 15, PRIO_PERMANENT, (1 << VOICE_W) - 1, '1), 0);
		push_req(mk_item(FN_UNUSED_HI, 15, PRIO_PERMANENT, (1 << VOICE_W) - 1, '1), 0);
		settle();

		// Directed ranges:
		//   g0 = 2..2 (the external voice), g1 = 4..6, g2 empty, g3 = 0..63 clamped,
		//   g4 straddles the cores, g5 and g6 single voices either side of the boundary.
		range_words[0] = {span(0, 63), span(10, 9), span(4, 6), span(2, 2)};
		range_words[1] = {span(0, NV - 1), span(VPC - 1, VPC - 1), span(VPC, VPC),
			span(VPC - 4, VPC + 3)};
		range_words[2] = RANGE_RESET;
		range_words[3] = {4{span(44, 47)}};
		load_ranges();
		// Victim at range start is external: refused even at top priority.
		push_req(mk_item(FN_ALLOC, 0, PRIO_PERMANENT, 0, 4), pick_gap());
		// Fill g1, then steal on a full tie (lowest index wins).
		repeat (4) push_req(mk_item(FN_ALLOC, 1, 10, 0, 5), pick_gap());
		// Requester below the victim: refused.
		push_req(mk_item(FN_ALLOC, 1, 9, 0, 6), pick_gap());
		// Steal all three at top priority, then the no-steal threshold refuses.
		repeat (4) push_req(mk_item(FN_ALLOC, 1, PRIO_PERMANENT, 0, 7), pick_gap());
		// Empty range refuses both kinds of allocation.
		push_req(mk_item(FN_ALLOC, 2, 50, 0, 8), pick_gap());
		push_req(mk_item(FN_ALLOC_NOISE, 2, 50, 0, 8), pick_gap());
		// Noise on a core 1 only range steals the busy noise voice there.
		push_req(mk_item(FN_ALLOC_NOISE, 5, 2, 0, 9), pick_gap());
		// Clamped max, extern grant.
		push_req(mk_item(FN_ALLOC_EXT, 3, 0, 0, '1), pick_gap());
		settle();

		// Random phases: reset ranges, all-zero and all-one extremes, then random mixes.
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					foreach (range_words[i])
						range_words[i] = RANGE_RESET;
					n_items = 150;
				end
				1: begin
					foreach (range_words[i])
						range_words[i] = '0;
					n_items = 100;
				end
				2: begin
					foreach (range_words[i])
						range_words[i] = '1;
					n_items = 40;
				end
				default: begin
					foreach (range_words[i])
						range_words[i] = rand_range_word();
					n_items = 212;
				end
			endcase
			load_ranges();
			// Every fifth stretch of 20 transactions goes without sender gaps.
			for (n = 0; n < n_items; n++)
				push_req(rand_item(), (n % 100 >= 80) ? 0 : pick_gap());
			settle();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Result side: random stalls, calm stretches, and a long periodic hold-off
	// that backs the block up until it refuses new requests.
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			rsp_taken++;
	end

	always @(negedge clk) begin
		rcv_cyc++;
		if (rsp_taken >= choke_at) begin
			stall_left = CHOKE_LEN;
			choke_at += CHOKE_EVERY;
		end else if (stall_left == 0 && (rcv_cyc / 2000) % 4 != 1 &&
				$urandom_range(0, 2) == 0) begin
			stall_left = pick_gap();
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached, %0d results still due", $time, pending);
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

// ===== priority_voice_allocator.f =====
+incdir+rtl/core
rtl/core/pva_pkg.sv
rtl/core/priority_voice_allocator.sv
test/voice_alloc_checker.sv
test/priority_voice_allocator_tb.sv
